>>> rtl/core/bleadv_pkg.sv
package bleadv_pkg;

	// Event codes recognized by the parser
	localparam logic [7:0] LE_META_CODE          = 8'h3E;
	localparam logic [7:0] EXT_ADV_SUBEVENT      = 8'h0D;
	localparam logic [7:0] EVENT_INDICATOR_RESET = 8'h04;

	// A report carries 24 fixed bytes before its data
	localparam int         ReportFixedBytes   = 24;
	localparam logic [4:0] REPORT_LAST_OFFSET = 5'(ReportFixedBytes - 1);

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Output queue: power of two so the pointers wrap on their own
	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = $clog2(FifoDepth);
	localparam int FifoCntW  = $clog2(FifoDepth + 1);

	typedef struct packed {
		logic [1:0]         kind;
		logic [15:0]        event_type;
		logic [47:0]        address;
		logic [7:0]         address_type;
		logic [7:0]         set_id;
		logic signed [7:0]  tx_dbm;
		logic signed [7:0]  rssi;
		logic [7:0]         data_length;
		logic [7:0]         data_byte;
		logic               parse_error;
		logic [3:0]         report_count;
		logic               last;
	} result_t;

	// Up to two results written in one cycle, first before second
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

>>> rtl/core/ble_ext_adv_report_parser.sv
// Each result word passes through the output queue; it is written when its input word is taken.
// Throughput: one input word per cycle while s_axis_tready is high; a word that yields a
// report result and the end status puts two words in the four-entry output queue, which
// drains one word per cycle while m_axis_tready is high. s_axis_tready is high while the
// output queue has room for two words. Reset (arst_n low, asynchronous): parse state
// cleared, event indicator set to 4, output queue emptied.
module ble_ext_adv_report_parser #(
	parameter int MAX_PACKET_BYTES = 1023
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [7:0] packet_byte, [17:8] packet_length, [23:18] zero
	input  logic [23:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [15:0] event_type, [63:16] address, [71:64] address_type, [79:72] set_id,
	// [87:80] tx_dbm, [95:88] rssi, [103:96] data_length, [111:104] data_byte,
	// [112] parse_error, [116:113] report_count, [119:117] zero
	output logic [119:0] m_axis_tdata,
	// [1:0] result_kind
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	logic                accept;
	logic                space2;
	bleadv_pkg::push_t   push;
	bleadv_pkg::result_t res;

	assign s_axis_tready = space2;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Byte parser
	bleadv_parse #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.packet_byte  (s_axis_tdata[7:0]),
		.packet_length(s_axis_tdata[17:8]),
		.push         (push)
	);

	// Result queue between parser and master side
	bleadv_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space2   (space2),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (res)
	);

	// Pack the result word
	assign m_axis_tdata = {3'b000, res.report_count, res.parse_error, res.data_byte,
		res.data_length, res.rssi, res.tx_dbm, res.set_id, res.address_type,
		res.address, res.event_type};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

>>> rtl/core/bleadv_parse.sv
module bleadv_parse #(
	parameter int MAX_PACKET_BYTES = 1023
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  logic                accept,
	input  logic [7:0]          packet_byte,
	input  logic [9:0]          packet_length,
	output bleadv_pkg::push_t   push
);

	localparam int LenW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int CmpW = ((LenW > 10) ? LenW : 10) + 1;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_REPORT = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	logic [7:0]  ev_ind_q;
	logic [9:0]  pos_q;
	logic [7:0]  code_q;
	logic [7:0]  plen_q;
	logic [1:0]  phase_q;
	logic [7:0]  rep_left_q;
	logic [4:0]  off_q;
	logic [7:0]  data_left_q;
	logic [3:0]  cnt_q;
	logic        err_q;

	logic [15:0]       evt_q;
	logic [47:0]       addr_q;
	logic [7:0]        atype_q;
	logic [7:0]        sid_q;
	logic signed [7:0] txp_q;
	logic signed [7:0] rssi_q;

	logic [9:0]  n_pos;
	logic [7:0]  n_code;
	logic [7:0]  n_plen;
	logic [1:0]  n_phase;
	logic [7:0]  n_rep_left;
	logic [4:0]  n_off;
	logic [7:0]  n_data_left;
	logic [3:0]  n_cnt;
	logic        n_err;

	logic [CmpW-1:0] len_raw;
	logic [CmpW-1:0] len_c;
	logic [CmpW-1:0] pos1;
	logic [CmpW-1:0] end_pos;
	logic            fits;
	logic            do_begin;
	logic [7:0]      begin_left;
	logic [7:0]      data_left_dec;
	logic            is_last;
	logic            a_valid;
	bleadv_pkg::result_t res_a;
	bleadv_pkg::result_t res_s;

	// Clamp the buffer length into 1..MAX_PACKET_BYTES
	always_comb begin
		len_raw = CmpW'(packet_length);
		if (len_raw == '0) begin
			len_c = CmpW'(1);
		end else if (len_raw > CmpW'(MAX_PACKET_BYTES)) begin
			len_c = CmpW'(MAX_PACKET_BYTES);
		end else begin
			len_c = len_raw;
		end
	end

	assign pos1          = CmpW'(pos_q) + CmpW'(1);
	assign end_pos       = CmpW'(plen_q) + CmpW'(3);
	assign fits          = (CmpW'(pos_q) + CmpW'(bleadv_pkg::ReportFixedBytes + 1)) <= end_pos;
	assign data_left_dec = data_left_q - 8'd1;
	assign is_last       = pos1 >= len_c;

	// Parse one byte: next state and up to two results
	always_comb begin
		n_pos       = pos_q;
		n_code      = code_q;
		n_plen      = plen_q;
		n_phase     = phase_q;
		n_rep_left  = rep_left_q;
		n_off       = off_q;
		n_data_left = data_left_q;
		n_cnt       = cnt_q;
		n_err       = err_q;
		do_begin    = 1'b0;
		begin_left  = rep_left_q;
		a_valid     = 1'b0;
		res_a       = '0;
		res_s       = '0;

		case (phase_q)
			PH_HEADER: begin
				if (pos_q == 10'd0) begin
					if (packet_byte != ev_ind_q) begin
						n_err   = 1'b1;
						n_phase = PH_DONE;
					end
				end else if (pos_q == 10'd1) begin
					n_code = packet_byte;
				end else if (pos_q == 10'd2) begin
					n_plen = packet_byte;
					if (CmpW'(packet_byte) + CmpW'(3) > len_c) begin
						n_err   = 1'b1;
						n_phase = PH_DONE;
					end else if (code_q != bleadv_pkg::LE_META_CODE || packet_byte < 8'd2) begin
						n_phase = PH_DONE;
					end
				end else if (pos_q == 10'd3) begin
					if (packet_byte != bleadv_pkg::EXT_ADV_SUBEVENT) begin
						n_phase = PH_DONE;
					end
				end else begin
					n_rep_left = packet_byte;
					do_begin   = 1'b1;
					begin_left = packet_byte;
				end
			end
			PH_REPORT: begin
				if (off_q >= bleadv_pkg::REPORT_LAST_OFFSET) begin
					if (pos1 + CmpW'(packet_byte) > end_pos) begin
						n_err   = 1'b1;
						n_phase = PH_DONE;
					end else begin
						a_valid            = 1'b1;
						res_a.kind         = bleadv_pkg::KIND_HEADER;
						res_a.event_type   = evt_q;
						res_a.address      = addr_q;
						res_a.address_type = atype_q;
						res_a.set_id       = sid_q;
						res_a.tx_dbm       = txp_q;
						res_a.rssi         = rssi_q;
						res_a.data_length  = packet_byte;
						if (cnt_q != 4'd15) begin
							n_cnt = cnt_q + 4'd1;
						end
						if (packet_byte == 8'd0) begin
							n_rep_left = rep_left_q - 8'd1;
							do_begin   = 1'b1;
							begin_left = rep_left_q - 8'd1;
						end else begin
							n_data_left = packet_byte;
							n_phase     = PH_DATA;
						end
					end
				end else begin
					n_off = off_q + 5'd1;
				end
			end
			PH_DATA: begin
				a_valid         = 1'b1;
				res_a.kind      = bleadv_pkg::KIND_DATA;
				res_a.data_byte = packet_byte;
				n_data_left     = data_left_dec;
				if (data_left_dec == 8'd0) begin
					n_rep_left = rep_left_q - 8'd1;
					do_begin   = 1'b1;
					begin_left = rep_left_q - 8'd1;
				end
			end
			default: begin
			end
		endcase

		// Start the next report, or finish when none is left or it cannot fit
		if (do_begin) begin
			if (begin_left == 8'd0) begin
				n_phase = PH_DONE;
			end else if (!fits) begin
				n_phase = PH_DONE;
				n_err   = 1'b1;
			end else begin
				n_phase = PH_REPORT;
				n_off   = 5'd0;
			end
		end

		// Close the packet on its last byte and return to the reset state
		res_a.last = !is_last;
		if (is_last) begin
			res_s.kind         = bleadv_pkg::KIND_STATUS;
			res_s.parse_error  = n_err | (n_phase != PH_DONE);
			res_s.report_count = n_cnt;
			res_s.last         = 1'b1;
			n_pos       = 10'd0;
			n_code      = 8'd0;
			n_plen      = 8'd0;
			n_phase     = PH_HEADER;
			n_rep_left  = 8'd0;
			n_off       = 5'd0;
			n_data_left = 8'd0;
			n_cnt       = 4'd0;
			n_err       = 1'b0;
		end else begin
			n_pos = pos1[9:0];
		end
	end

	// Hand results to the output queue, report result first
	always_comb begin
		push        = '0;
		push.second = res_s;
		push.first  = a_valid ? res_a : res_s;
		if (accept) begin
			push.count = 2'({1'b0, a_valid} + {1'b0, is_last});
		end
	end

	// Parse state and the indicator register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_ind_q    <= bleadv_pkg::EVENT_INDICATOR_RESET;
			pos_q       <= 10'd0;
			code_q      <= 8'd0;
			plen_q      <= 8'd0;
			phase_q     <= PH_HEADER;
			rep_left_q  <= 8'd0;
			off_q       <= 5'd0;
			data_left_q <= 8'd0;
			cnt_q       <= 4'd0;
			err_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				ev_ind_q <= cfg_wdata;
			end
			if (accept) begin
				pos_q       <= n_pos;
				code_q      <= n_code;
				plen_q      <= n_plen;
				phase_q     <= n_phase;
				rep_left_q  <= n_rep_left;
				off_q       <= n_off;
				data_left_q <= n_data_left;
				cnt_q       <= n_cnt;
				err_q       <= n_err;
			end
		end
	end

	// Capture the fixed report bytes that the header result carries
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_REPORT) begin
			case (off_q)
				5'd0:    evt_q[7:0]     <= packet_byte;
				5'd1:    evt_q[15:8]    <= packet_byte;
				5'd2:    atype_q        <= packet_byte;
				5'd3:    addr_q[7:0]    <= packet_byte;
				5'd4:    addr_q[15:8]   <= packet_byte;
				5'd5:    addr_q[23:16]  <= packet_byte;
				5'd6:    addr_q[31:24]  <= packet_byte;
				5'd7:    addr_q[39:32]  <= packet_byte;
				5'd8:    addr_q[47:40]  <= packet_byte;
				5'd11:   sid_q          <= packet_byte;
				5'd12:   txp_q          <= packet_byte;
				5'd13:   rssi_q         <= packet_byte;
				default: begin
				end
			endcase
		end
	end

	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		off_q <= bleadv_pkg::REPORT_LAST_OFFSET)
		else $error("report offset past the fixed part");

	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> data_left_q != 8'd0)
		else $error("data phase with no data left");

	a_report_after_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_REPORT |-> pos_q >= 10'd5)
		else $error("report phase before the report count byte");

endmodule

>>> rtl/core/bleadv_fifo.sv
module bleadv_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bleadv_pkg::push_t    push,
	output logic                 space2,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bleadv_pkg::result_t  out_data
);

	localparam int PtrW = bleadv_pkg::FifoPtrW;
	localparam int CntW = bleadv_pkg::FifoCntW;

	bleadv_pkg::result_t mem_q [bleadv_pkg::FifoDepth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic            pop;

	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign space2    = cnt_q <= CntW'(bleadv_pkg::FifoDepth - 2);

	// Write up to two words at the tail
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[PtrW'(wr_q + 1'b1)] <= push.second;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= PtrW'(wr_q + PtrW'(push.count));
			rd_q  <= PtrW'(rd_q + PtrW'(pop));
			cnt_q <= CntW'(cnt_q + CntW'(push.count) - CntW'(pop));
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(bleadv_pkg::FifoDepth))
		else $error("output queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> (cnt_q + CntW'(push.count)) <= CntW'(bleadv_pkg::FifoDepth))
		else $error("push without room");

	a_push_two_max: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two words pushed");

endmodule

>>> verif/tb_ble_ext_adv_report_parser.sv
package tb_bleadv_pkg;

	localparam int PacketByteLimit = 1023;

	typedef enum logic [1:0] {
		PARSE_HEADER,
		PARSE_FIXED,
		PARSE_DATA,
		PARSE_DONE
	} parse_stage_t;

	class report_scoreboard;
		logic [7:0]   indicator;
		logic [9:0]   byte_pos;
		logic [7:0]   code_seen;
		logic [7:0]   param_len;
		parse_stage_t stage;
		logic [7:0]   reports_left;
		logic [4:0]   fixed_offset;
		logic [7:0]   data_left;
		logic [63:0]  shift_lo;
		logic [63:0]  shift_hi;
		logic [3:0]   delivered;
		logic         error_flag;
		bleadv_pkg::result_t awaited_results[$];
		int           errors;

		function new();
			indicator = bleadv_pkg::EVENT_INDICATOR_RESET;
			errors    = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			byte_pos     = '0;
			code_seen    = '0;
			param_len    = '0;
			stage        = PARSE_HEADER;
			reports_left = '0;
			fixed_offset = '0;
			data_left    = '0;
			shift_lo     = '0;
			shift_hi     = '0;
			delivered    = '0;
			error_flag   = 1'b0;
		endfunction

		function void set_indicator(logic [7:0] value);
			indicator = value;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function void abort_packet();
			error_flag = 1'b1;
			stage      = PARSE_DONE;
		endfunction

		// Decide what follows once the word before next_pos is consumed
		function void start_report(int next_pos);
			if (reports_left == 0) begin
				stage = PARSE_DONE;
			end else if (next_pos + bleadv_pkg::ReportFixedBytes > 3 + int'(param_len)) begin
				abort_packet();
			end else begin
				stage        = PARSE_FIXED;
				fixed_offset = '0;
				shift_lo     = '0;
				shift_hi     = '0;
			end
		endfunction

		// Advance the parse by one accepted word and queue the results it causes
		function void take_byte(logic [7:0] b, logic [9:0] len_field);
			bleadv_pkg::result_t made[2];
			bleadv_pkg::result_t r;
			int         len;
			int         pos;
			int         end_pos;
			int         n;
			logic [4:0] off;

			len = (len_field == 0) ? 1 : int'(len_field);
			if (len > PacketByteLimit)
				len = PacketByteLimit;
			pos     = int'(byte_pos);
			end_pos = 3 + int'(param_len);
			n       = 0;

			case (stage)
				PARSE_HEADER: begin
					if (pos == 0) begin
						if (b != indicator)
							abort_packet();
					end else if (pos == 1) begin
						code_seen = b;
					end else if (pos == 2) begin
						param_len = b;
						if (3 + b > len)
							abort_packet();
						else if (code_seen != bleadv_pkg::LE_META_CODE || b < 2)
							stage = PARSE_DONE;
					end else if (pos == 3) begin
						if (b != bleadv_pkg::EXT_ADV_SUBEVENT)
							stage = PARSE_DONE;
					end else begin
						reports_left = b;
						start_report(pos + 1);
					end
				end
				PARSE_FIXED: begin
					off = fixed_offset;
					if (off < 8)
						shift_lo |= 64'(b) << (8 * off);
					else if (off < 16)
						shift_hi |= 64'(b) << (8 * (off - 8));
					if (off >= bleadv_pkg::REPORT_LAST_OFFSET) begin
						if (pos + 1 + b > end_pos) begin
							abort_packet();
						end else begin
							r              = '0;
							r.kind         = bleadv_pkg::KIND_HEADER;
							r.event_type   = shift_lo[15:0];
							r.address      = {shift_hi[7:0], shift_lo[63:24]};
							r.address_type = shift_lo[23:16];
							r.set_id       = shift_hi[31:24];
							r.tx_dbm       = shift_hi[39:32];
							r.rssi         = shift_hi[47:40];
							r.data_length  = b;
							made[n]        = r;
							n++;
							if (delivered != 4'hF)
								delivered++;
							if (b == 0) begin
								reports_left--;
								start_report(pos + 1);
							end else begin
								data_left = b;
								stage     = PARSE_DATA;
							end
						end
					end else begin
						fixed_offset = 5'(off + 1);
					end
				end
				PARSE_DATA: begin
					r           = '0;
					r.kind      = bleadv_pkg::KIND_DATA;
					r.data_byte = b;
					made[n]     = r;
					n++;
					data_left--;
					if (data_left == 0) begin
						reports_left--;
						start_report(pos + 1);
					end
				end
				default: ;
			endcase

			// Close the packet on its last word
			if (pos + 1 >= len) begin
				if (stage != PARSE_DONE)
					error_flag = 1'b1;
				r              = '0;
				r.kind         = bleadv_pkg::KIND_STATUS;
				r.parse_error  = error_flag;
				r.report_count = delivered;
				made[n]        = r;
				n++;
				clear_packet();
			end else begin
				byte_pos = 10'(pos + 1);
			end

			for (int i = 0; i < n; i++) begin
				if (i == n - 1)
					made[i].last = 1'b1;
				awaited_results.push_back(made[i]);
			end
		endfunction

		function void compare(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		// Match one output word against the oldest queued result
		function void check_result(bleadv_pkg::result_t got);
			bleadv_pkg::result_t want;
			if (awaited_results.size() == 0) begin
				$error("result word with none queued: kind %0h", got.kind);
				errors++;
				return;
			end
			want = awaited_results.pop_front();
			compare("result_kind", want.kind, got.kind);
			compare("event_type", want.event_type, got.event_type);
			compare("address", want.address, got.address);
			compare("address_type", want.address_type, got.address_type);
			compare("set_id", want.set_id, got.set_id);
			compare("tx_dbm", want.tx_dbm, got.tx_dbm);
			compare("rssi", want.rssi, got.rssi);
			compare("data_length", want.data_length, got.data_length);
			compare("data_byte", want.data_byte, got.data_byte);
			compare("parse_error", want.parse_error, got.parse_error);
			compare("report_count", want.report_count, got.report_count);
			compare("last_result", want.last, got.last);
		endfunction
	endclass

endpackage

module tb_ble_ext_adv_report_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PhaseItems     = 200;
	localparam int IdleLimit      = 2000;
	localparam int PressureCycles = 250;
	localparam int SettleCycles   = 8;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [7:0]   cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [23:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [119:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;

	tb_bleadv_pkg::report_scoreboard sb;
	logic [7:0]       pkt_bytes[$];
	logic [9:0]       pkt_lens[$];
	bit               burst = 1'b0;
	int               items_sent = 0;
	int               idle_cycles = 0;

	ble_ext_adv_report_parser #(
		.MAX_PACKET_BYTES(tb_bleadv_pkg::PacketByteLimit)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one input word and hold it until taken
	task automatic send_word(input logic [7:0] b, input logic [9:0] len);
		int gap;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, len, b};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.take_byte(b, len);
		items_sent++;
	endtask

	// Send up to six words, first word in the low byte
	task automatic send_bytes(input int count, input logic [47:0] bytes, input logic [9:0] len);
		for (int i = 0; i < count; i++)
			send_word(bytes[8 * i +: 8], len);
	endtask

	task automatic send_packet();
		burst = ($urandom_range(0, 3) == 0);
		foreach (pkt_bytes[i])
			send_word(pkt_bytes[i], pkt_lens[i]);
	endtask

	// Drop valid, let queued results drain, then let the pipeline settle
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_indicator(input logic [7:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_indicator(value);
	endtask

	// Build a well-formed extended report event; return the index of the
	// last report's data length word, or -1 without reports
	function automatic int build_event(input logic [7:0] ind, input int n_reports);
		logic [7:0] params[$];
		int         room;
		int         dlen;
		int         dlen_idx;
		dlen_idx = -1;
		params.push_back(bleadv_pkg::EXT_ADV_SUBEVENT);
		params.push_back(8'(n_reports));
		for (int i = 0; i < n_reports; i++) begin
			room = 255 - params.size() - bleadv_pkg::ReportFixedBytes * (n_reports - i);
			if ($urandom_range(0, 3) != 0)
				dlen = $urandom_range(0, (room < 4) ? room : 4);
			else
				dlen = $urandom_range(0, (room < 40) ? room : 40);
			repeat (bleadv_pkg::ReportFixedBytes - 1) params.push_back(8'($urandom));
			dlen_idx = params.size() + 3;
			params.push_back(8'(dlen));
			repeat (dlen) params.push_back(8'($urandom));
		end
		pkt_bytes.delete();
		pkt_bytes.push_back(ind);
		pkt_bytes.push_back(bleadv_pkg::LE_META_CODE);
		pkt_bytes.push_back(8'(params.size()));
		foreach (params[i])
			pkt_bytes.push_back(params[i]);
		return dlen_idx;
	endfunction

	// Generate one packet, mostly well-formed, and send it
	task automatic run_packet(input logic [7:0] ind);
		int kind;
		int n;
		int idx;
		int k;
		int cut;

		kind = $urandom_range(0, 99);
		if (kind >= 55)
			n = $urandom_range(1, 2);
		else if ($urandom_range(0, 9) == 0)
			n = $urandom_range(5, 10);
		else
			n = $urandom_range(0, 3);
		idx = build_event(ind, n);

		if (kind < 55) begin
			// trailing words past the parameters
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom));
		end else if (kind < 60) begin
			pkt_bytes[0] = ind ^ 8'($urandom_range(1, 255));
		end else if (kind < 64) begin
			pkt_bytes[1] = bleadv_pkg::LE_META_CODE ^ 8'($urandom_range(1, 255));
		end else if (kind < 68) begin
			pkt_bytes[2] = 8'($urandom_range(0, 1));
		end else if (kind < 72) begin
			pkt_bytes[3] = bleadv_pkg::EXT_ADV_SUBEVENT ^ 8'($urandom_range(1, 255));
		end else if (kind < 77) begin
			// truncated buffer: shorter than the parameter length claims
			cut = $urandom_range(3, pkt_bytes.size() - 1);
			while (pkt_bytes.size() > cut)
				void'(pkt_bytes.pop_back());
		end else if (kind < 81) begin
			// more reports claimed than fit
			pkt_bytes[4] = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'(n + $urandom_range(1, 3));
		end else if (kind < 85) begin
			// last report's data runs past the parameters
			if (idx >= 0)
				pkt_bytes[idx] = 8'($urandom_range(int'(pkt_bytes[idx]) + 1, 255));
		end else if (kind >= 94 && kind < 97) begin
			pkt_bytes.delete();
			pkt_bytes.push_back(($urandom_range(0, 1) == 0) ? ind : 8'($urandom));
			if ($urandom_range(0, 1) == 0)
				pkt_bytes.push_back(bleadv_pkg::LE_META_CODE);
		end else if (kind >= 97) begin
			pkt_bytes.delete();
			pkt_bytes.push_back(($urandom_range(0, 1) == 0) ? ind : 8'($urandom));
			repeat ($urandom_range(0, 40)) pkt_bytes.push_back(8'($urandom));
		end

		pkt_lens.delete();
		foreach (pkt_bytes[i])
			pkt_lens.push_back(10'(pkt_bytes.size()));

		if (kind >= 85 && kind < 90) begin
			// length drops mid packet and ends it early
			k = $urandom_range(0, pkt_bytes.size() - 2);
			while (pkt_bytes.size() > k + 1) begin
				void'(pkt_bytes.pop_back());
				void'(pkt_lens.pop_back());
			end
			pkt_lens[k] = 10'($urandom_range(0, k + 1));
		end else if (kind >= 90 && kind < 94) begin
			// length jumps on one word without ending the packet
			k = $urandom_range(0, pkt_bytes.size() - 2);
			pkt_lens[k] = 10'($urandom_range(k + 2, tb_bleadv_pkg::PacketByteLimit));
		end else if (kind >= 94 && kind < 97) begin
			if (pkt_bytes.size() == 1 && $urandom_range(0, 1) == 0)
				pkt_lens[0] = 10'd0;
		end

		send_packet();
	endtask

	// Short packets covering the header-level corner cases
	task automatic run_directed();
		send_bytes(1, 48'h04, 10'd1);
		send_bytes(1, 48'hAB, 10'd0);
		send_bytes(2, 48'h3E04, 10'd2);
		send_bytes(3, 48'h003E00, 10'd3);
		send_bytes(3, 48'h00FF04, 10'd3);
		send_bytes(4, 48'hFF013E04, 10'd4);
		send_bytes(5, 48'h00000D023E04, 10'd5);
		send_bytes(5, 48'hFF000A3E04, 10'd5);
		send_bytes(6, 48'h00000C033E04, 10'd6);
	endtask

	// Receiver: random stalls, one long hold-off to back up the block
	initial begin
		int round;
		int r;
		round         = 0;
		m_axis_tready = 1'b0;
		repeat (6) @(posedge clk);
		forever begin
			round++;
			r = $urandom_range(0, 19);
			if (round == 40) begin
				m_axis_tready <= 1'b0;
				repeat (PressureCycles) @(posedge clk);
			end else if (r < 11) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else if (r < 13) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(40, 120)) @(posedge clk);
			end else if (r < 18) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// Check every result word taken on the master side
	always @(posedge clk) begin
		bleadv_pkg::result_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.kind         = m_axis_tuser;
			got.event_type   = m_axis_tdata[15:0];
			got.address      = m_axis_tdata[63:16];
			got.address_type = m_axis_tdata[71:64];
			got.set_id       = m_axis_tdata[79:72];
			got.tx_dbm       = m_axis_tdata[87:80];
			got.rssi         = m_axis_tdata[95:88];
			got.data_length  = m_axis_tdata[103:96];
			got.data_byte    = m_axis_tdata[111:104];
			got.parse_error  = m_axis_tdata[112];
			got.report_count = m_axis_tdata[116:113];
			got.last         = m_axis_tlast;
			sb.check_result(got);
		end
	end

	// Stop the run when neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [7:0] settings[5];
		int         phase_start;

		sb            = new();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		settings      = '{bleadv_pkg::EVENT_INDICATOR_RESET, 8'h00, 8'hFF, 8'($urandom),
			bleadv_pkg::EVENT_INDICATOR_RESET};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// One phase per indicator setting; the first keeps the reset value
		foreach (settings[i]) begin
			if (i > 0)
				write_indicator(settings[i]);
			phase_start = items_sent;
			while (items_sent - phase_start < PhaseItems)
				run_packet(settings[i]);
		end

		wait_drained();
		@(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
